### rtl/cbd_pkg.sv
// Shared types and constants for the console bus decoder with mirrored RAM.
// Holds the address map, field codes, item structs and memory geometry.
// No dependencies; every other file except cbd_ram uses it through scoped names.
`default_nettype none

package cbd_pkg;

   // Memory geometry.
   localparam int WORK_RAM_DEPTH   = 2048;
   localparam int NAME_TABLE_DEPTH = 4096;
   localparam int PALETTE_DEPTH    = 32;
   localparam int WRAM_AW = $clog2(WORK_RAM_DEPTH);
   localparam int NT_AW   = $clog2(NAME_TABLE_DEPTH);
   localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
   localparam int PPU_AW  = 14;

   // Access kinds.
   localparam logic [1:0] FUNC_CPU_READ  = 2'd0;
   localparam logic [1:0] FUNC_CPU_WRITE = 2'd1;
   localparam logic [1:0] FUNC_PPU_READ  = 2'd2;
   localparam logic [1:0] FUNC_PPU_WRITE = 2'd3;

   // Target codes.
   localparam logic [2:0] TGT_NONE = 3'd0;
   localparam logic [2:0] TGT_PPU  = 3'd1;
   localparam logic [2:0] TGT_APU  = 3'd2;
   localparam logic [2:0] TGT_CTRL = 3'd3;
   localparam logic [2:0] TGT_DMA  = 3'd4;
   localparam logic [2:0] TGT_PRG  = 3'd5;
   localparam logic [2:0] TGT_CHR  = 3'd6;

   // Name table mirroring modes; codes above horizontal act as four-screen.
   localparam logic [2:0] MIR_SINGLE_LO  = 3'd0;
   localparam logic [2:0] MIR_SINGLE_HI  = 3'd1;
   localparam logic [2:0] MIR_VERTICAL   = 3'd2;
   localparam logic [2:0] MIR_HORIZONTAL = 3'd3;

   // CPU address map.
   localparam logic [15:0] ADDR_PPU_BASE   = 16'h2000;
   localparam logic [15:0] ADDR_APU_BASE   = 16'h4000;
   localparam logic [15:0] ADDR_APU_LAST   = 16'h4013;
   localparam logic [15:0] ADDR_OAM_DMA    = 16'h4014;
   localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
   localparam logic [15:0] ADDR_CTRL0      = 16'h4016;
   localparam logic [15:0] ADDR_CTRL1      = 16'h4017;
   localparam logic [15:0] ADDR_CART_BASE  = 16'h4100;
   localparam logic [7:0]  APU_REG_UNUSED0 = 8'h09;
   localparam logic [7:0]  APU_REG_UNUSED1 = 8'h0D;
   localparam logic [15:0] DMA_INDEX       = 16'd4;
   localparam logic [15:0] CTRL_ALL        = 16'd2;
   localparam logic [7:0]  OBUS_MASK       = 8'h20;

   // PPU address map.
   localparam logic [PPU_AW-1:0] PPU_NT_BASE  = 14'h2000;
   localparam logic [PPU_AW-1:0] PPU_PAL_BASE = 14'h3F00;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [7:0]  ext_read_data;
      logic        ext_present;
      logic [2:0]  mirror_mode;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [2:0]  target;
      logic [15:0] target_index;
      logic        target_write;
      logic [7:0]  target_data;
   } rsp_type;

   // Where the read byte of an item comes from.
   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_EXT,
      SRC_EXT_OBUS,
      SRC_LATCH,
      SRC_WRAM,
      SRC_NT,
      SRC_PAL
   } rd_src_type;

   typedef enum logic [1:0] {
      LATCH_KEEP,
      LATCH_READ,
      LATCH_WRITE
   } latch_op_type;

   // Decoded item held between the memory read and the result.
   typedef struct packed {
      rd_src_type   rd_src;
      latch_op_type latch_op;
      logic [7:0]   ext_data;
      logic [7:0]   wr_data;
      logic [2:0]   target;
      logic [15:0]  target_index;
      logic         target_write;
      logic [7:0]   target_data;
   } pipe_type;

   typedef struct packed {
      logic [WRAM_AW-1:0] wram_addr;
      logic               wram_we;
      logic [NT_AW-1:0]   nt_addr;
      logic               nt_we;
      logic [PAL_AW-1:0]  pal_addr;
      logic               pal_we;
      logic [7:0]         wdata;
   } mem_req_type;

   typedef enum logic {
      CLR_RUN,
      CLR_DONE
   } clr_state_type;

   typedef struct packed {
      logic             active;
      logic [NT_AW-1:0] addr;
   } clr_type;

endpackage

`default_nettype wire

### rtl/cbd_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Standalone; used for work RAM, name table RAM and palette RAM.
`default_nettype none

module cbd_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/cbd_decode.sv
// Address decoder: turns one bus access into memory requests and a decoded item.
// Depends on cbd_pkg for the address map, codes and structs.
`default_nettype none

module cbd_decode (
   input  wire cbd_pkg::req_type     req,
   output cbd_pkg::mem_req_type      mem_req,
   output cbd_pkg::pipe_type         pipe
);

   logic [cbd_pkg::PPU_AW-1:0] ppu_addr;
   logic [cbd_pkg::NT_AW-1:0]  nt_index;
   logic [cbd_pkg::PAL_AW-1:0] pal_index;
   logic                       ppu_read;

   assign ppu_addr = req.addr[cbd_pkg::PPU_AW-1:0];
   assign ppu_read = (req.func == cbd_pkg::FUNC_PPU_READ);

   always_comb begin
      case (req.mirror_mode)
         cbd_pkg::MIR_SINGLE_LO:  nt_index = {2'b00, ppu_addr[9:0]};
         cbd_pkg::MIR_SINGLE_HI:  nt_index = {2'b01, ppu_addr[9:0]};
         cbd_pkg::MIR_VERTICAL:   nt_index = {1'b0, ppu_addr[10:0]};
         cbd_pkg::MIR_HORIZONTAL: nt_index = {1'b0, ppu_addr[11], ppu_addr[9:0]};
         default:                 nt_index = ppu_addr[cbd_pkg::NT_AW-1:0];
      endcase
   end

   // Background color entries of the sprite palettes alias those of the background palettes.
   assign pal_index = (ppu_addr[1:0] == 2'b00) ? {1'b0, ppu_addr[3:0]}
                                               : ppu_addr[cbd_pkg::PAL_AW-1:0];

   always_comb begin
      mem_req.wram_addr = req.addr[cbd_pkg::WRAM_AW-1:0];
      mem_req.nt_addr   = nt_index;
      mem_req.pal_addr  = pal_index;
      mem_req.wdata     = req.data;
      mem_req.wram_we   = 1'b0;
      mem_req.nt_we     = 1'b0;
      mem_req.pal_we    = 1'b0;

      pipe.rd_src       = cbd_pkg::SRC_ZERO;
      pipe.latch_op     = cbd_pkg::LATCH_KEEP;
      pipe.ext_data     = req.ext_read_data;
      pipe.wr_data      = req.data;
      pipe.target       = cbd_pkg::TGT_NONE;
      pipe.target_index = 16'h0000;
      pipe.target_write = 1'b0;
      pipe.target_data  = 8'h00;

      case (req.func)
         cbd_pkg::FUNC_CPU_READ: begin
            pipe.latch_op = cbd_pkg::LATCH_READ;
            if (req.addr < cbd_pkg::ADDR_PPU_BASE) begin
               pipe.rd_src = cbd_pkg::SRC_WRAM;
            end else if (req.addr < cbd_pkg::ADDR_APU_BASE) begin
               pipe.target       = cbd_pkg::TGT_PPU;
               pipe.target_index = {13'h0000, req.addr[2:0]};
               pipe.rd_src       = cbd_pkg::SRC_EXT;
            end else if (req.addr == cbd_pkg::ADDR_APU_STATUS) begin
               pipe.target       = cbd_pkg::TGT_APU;
               pipe.target_index = {8'h00, req.addr[7:0]};
               pipe.rd_src       = cbd_pkg::SRC_EXT_OBUS;
            end else if (req.addr == cbd_pkg::ADDR_CTRL0 ||
                         req.addr == cbd_pkg::ADDR_CTRL1) begin
               pipe.target       = cbd_pkg::TGT_CTRL;
               pipe.target_index = {15'h0000, req.addr[0]};
               pipe.rd_src       = req.ext_present ? cbd_pkg::SRC_EXT : cbd_pkg::SRC_ZERO;
            end else if (req.addr >= cbd_pkg::ADDR_CART_BASE) begin
               pipe.target       = cbd_pkg::TGT_PRG;
               pipe.target_index = req.addr;
               pipe.rd_src       = cbd_pkg::SRC_EXT;
            end else begin
               pipe.rd_src = cbd_pkg::SRC_LATCH;
            end
         end
         cbd_pkg::FUNC_CPU_WRITE: begin
            pipe.latch_op = cbd_pkg::LATCH_WRITE;
            if (req.addr < cbd_pkg::ADDR_PPU_BASE) begin
               mem_req.wram_we = 1'b1;
            end else if (req.addr < cbd_pkg::ADDR_APU_BASE) begin
               pipe.target       = cbd_pkg::TGT_PPU;
               pipe.target_index = {13'h0000, req.addr[2:0]};
               pipe.target_write = 1'b1;
               pipe.target_data  = req.data;
            end else if (req.addr <= cbd_pkg::ADDR_APU_LAST) begin
               // The two unused APU registers swallow the write.
               if (req.addr[7:0] != cbd_pkg::APU_REG_UNUSED0 &&
                   req.addr[7:0] != cbd_pkg::APU_REG_UNUSED1) begin
                  pipe.target       = cbd_pkg::TGT_APU;
                  pipe.target_index = {8'h00, req.addr[7:0]};
                  pipe.target_write = 1'b1;
                  pipe.target_data  = req.data;
               end
            end else if (req.addr == cbd_pkg::ADDR_OAM_DMA) begin
               pipe.target       = cbd_pkg::TGT_DMA;
               pipe.target_index = cbd_pkg::DMA_INDEX;
               pipe.target_write = 1'b1;
               pipe.target_data  = req.data;
            end else if (req.addr == cbd_pkg::ADDR_APU_STATUS ||
                         req.addr == cbd_pkg::ADDR_CTRL1) begin
               pipe.target       = cbd_pkg::TGT_APU;
               pipe.target_index = {8'h00, req.addr[7:0]};
               pipe.target_write = 1'b1;
               pipe.target_data  = req.data;
            end else if (req.addr == cbd_pkg::ADDR_CTRL0) begin
               pipe.target       = cbd_pkg::TGT_CTRL;
               pipe.target_index = cbd_pkg::CTRL_ALL;
               pipe.target_write = 1'b1;
               pipe.target_data  = req.data;
            end else if (req.addr >= cbd_pkg::ADDR_CART_BASE) begin
               pipe.target       = cbd_pkg::TGT_PRG;
               pipe.target_index = req.addr;
               pipe.target_write = 1'b1;
               pipe.target_data  = req.data;
            end
         end
         default: begin
            if (ppu_addr < cbd_pkg::PPU_NT_BASE) begin
               pipe.target       = cbd_pkg::TGT_CHR;
               pipe.target_index = {2'b00, ppu_addr};
               if (ppu_read) begin
                  pipe.rd_src = cbd_pkg::SRC_EXT;
               end else begin
                  pipe.target_write = 1'b1;
                  pipe.target_data  = req.data;
               end
            end else if (ppu_addr < cbd_pkg::PPU_PAL_BASE) begin
               if (ppu_read) begin
                  pipe.rd_src = cbd_pkg::SRC_NT;
               end else begin
                  mem_req.nt_we = 1'b1;
               end
            end else begin
               if (ppu_read) begin
                  pipe.rd_src = cbd_pkg::SRC_PAL;
               end else begin
                  mem_req.pal_we = 1'b1;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/cbd_clear.sv
// Clearing sequencer: sweeps every memory entry to zero after reset.
// Depends on cbd_pkg for the sweep length and the state and status types.
`default_nettype none

module cbd_clear (
   input  wire logic        clock,
   input  wire logic        reset,
   output cbd_pkg::clr_type clr
);

   cbd_pkg::clr_state_type   state_ff, state_in;
   logic [cbd_pkg::NT_AW-1:0] count_ff, count_in;
   logic                      last;

   localparam logic [cbd_pkg::NT_AW-1:0] LAST_ENTRY =
      cbd_pkg::NT_AW'(cbd_pkg::NAME_TABLE_DEPTH - 1);

   assign last = (count_ff == LAST_ENTRY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbd_pkg::CLR_RUN;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cbd_pkg::CLR_RUN:  if (last) state_in = cbd_pkg::CLR_DONE;
         cbd_pkg::CLR_DONE: state_in = cbd_pkg::CLR_DONE;
         default:           state_in = cbd_pkg::CLR_RUN;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      clr.active = 1'b0;
      clr.addr   = count_ff;
      case (state_ff)
         cbd_pkg::CLR_RUN: begin
            clr.active = 1'b1;
            count_in   = count_ff + 1'b1;
         end
         default: begin
            clr.active = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/console_bus_decoder_with_mirrored_ram.sv
// Top level of the console bus decoder with mirrored RAM.
// Depends on cbd_pkg, cbd_decode, cbd_clear and cbd_ram.
//
//   channel   handshake            payload    direction
//   request   start / busy         req_data   in
//   response  rsp_valid (strobe)   rsp_data   out
//
// An item accepted at one clock edge gives its result in the cycle after; a new
// item may be accepted at every edge while busy is low, so the rate is one item per cycle.
// The result is delayed by the registered read port of the three RAMs.
// After reset, busy stays high while the name table sweep
// zeroes all memories; work RAM and palette RAM are cleared in the same pass.
// The result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module console_bus_decoder_with_mirrored_ram (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cbd_pkg::req_type req_data,
   output logic                  rsp_valid,
   output cbd_pkg::rsp_type      rsp_data
);

   cbd_pkg::mem_req_type mem_req;
   cbd_pkg::pipe_type    pipe_in, pipe_ff;
   cbd_pkg::clr_type     clr;
   logic                 accept;
   logic                 pipe_valid_ff;
   logic [7:0]           latch_ff, latch_in;
   logic [7:0]           rd;

   logic                       wram_we, nt_we, pal_we;
   logic [cbd_pkg::WRAM_AW-1:0] wram_addr;
   logic [cbd_pkg::NT_AW-1:0]   nt_addr;
   logic [cbd_pkg::PAL_AW-1:0]  pal_addr;
   logic [7:0]                  wdata;
   logic [7:0]                  wram_rdata, nt_rdata, pal_rdata;

   assign busy   = clr.active;
   assign accept = start && !busy;

   cbd_decode u_decode (
      .req     (req_data),
      .mem_req (mem_req),
      .pipe    (pipe_in)
   );

   cbd_clear u_clear (
      .clock (clock),
      .reset (reset),
      .clr   (clr)
   );

   // The sweep owns the memory ports until it finishes.
   always_comb begin
      if (clr.active) begin
         wram_we   = 1'b1;
         nt_we     = 1'b1;
         pal_we    = 1'b1;
         wram_addr = clr.addr[cbd_pkg::WRAM_AW-1:0];
         nt_addr   = clr.addr;
         pal_addr  = clr.addr[cbd_pkg::PAL_AW-1:0];
         wdata     = 8'h00;
      end else begin
         wram_we   = accept && mem_req.wram_we;
         nt_we     = accept && mem_req.nt_we;
         pal_we    = accept && mem_req.pal_we;
         wram_addr = mem_req.wram_addr;
         nt_addr   = mem_req.nt_addr;
         pal_addr  = mem_req.pal_addr;
         wdata     = mem_req.wdata;
      end
   end

   cbd_ram #(.DEPTH(cbd_pkg::WORK_RAM_DEPTH), .WIDTH(8)) u_wram (
      .clock (clock),
      .we    (wram_we),
      .re    (accept),
      .addr  (wram_addr),
      .wdata (wdata),
      .rdata (wram_rdata)
   );

   cbd_ram #(.DEPTH(cbd_pkg::NAME_TABLE_DEPTH), .WIDTH(8)) u_nt_ram (
      .clock (clock),
      .we    (nt_we),
      .re    (accept),
      .addr  (nt_addr),
      .wdata (wdata),
      .rdata (nt_rdata)
   );

   cbd_ram #(.DEPTH(cbd_pkg::PALETTE_DEPTH), .WIDTH(8)) u_pal_ram (
      .clock (clock),
      .we    (pal_we),
      .re    (accept),
      .addr  (pal_addr),
      .wdata (wdata),
      .rdata (pal_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
         latch_ff      <= 8'h00;
      end else begin
         pipe_valid_ff <= accept;
         latch_ff      <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pipe_ff <= pipe_in;
      end
   end

   // Items reach this stage in order, so the open-bus latch read here is
   // always the one left by the previous item.
   always_comb begin
      case (pipe_ff.rd_src)
         cbd_pkg::SRC_EXT:      rd = pipe_ff.ext_data;
         cbd_pkg::SRC_EXT_OBUS: rd = pipe_ff.ext_data | (latch_ff & cbd_pkg::OBUS_MASK);
         cbd_pkg::SRC_LATCH:    rd = latch_ff;
         cbd_pkg::SRC_WRAM:     rd = wram_rdata;
         cbd_pkg::SRC_NT:       rd = nt_rdata;
         cbd_pkg::SRC_PAL:      rd = pal_rdata;
         default:               rd = 8'h00;
      endcase
   end

   always_comb begin
      latch_in = latch_ff;
      if (pipe_valid_ff) begin
         case (pipe_ff.latch_op)
            cbd_pkg::LATCH_READ:  latch_in = rd;
            cbd_pkg::LATCH_WRITE: latch_in = pipe_ff.wr_data;
            default:              latch_in = latch_ff;
         endcase
      end
   end

   assign rsp_valid              = pipe_valid_ff;
   assign rsp_data.read_data     = rd;
   assign rsp_data.target        = pipe_ff.target;
   assign rsp_data.target_index  = pipe_ff.target_index;
   assign rsp_data.target_write  = pipe_ff.target_write;
   assign rsp_data.target_data   = pipe_ff.target_data;

endmodule

`default_nettype wire

### rtl/cbd_checker.sv
// Port-level checker for the console bus decoder, bound to the top level.
// Depends on cbd_pkg for the response struct and target codes.
`default_nettype none

module cbd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire cbd_pkg::rsp_type rsp_data
);

   // Every accepted item produces exactly one result on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("accepted item gave no result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without an accepted item");

   // The memory sweep holds the request side off right after reset.
   assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.target_write |-> rsp_data.read_data == 8'h00)
      else $error("write returned read data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.target == cbd_pkg::TGT_DMA |->
         rsp_data.target_write && rsp_data.target_index == cbd_pkg::DMA_INDEX)
      else $error("malformed sprite DMA request");

endmodule

bind console_bus_decoder_with_mirrored_ram cbd_checker u_cbd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
